// ----- hdl/adl32_pkg.sv -----
// ----------------------------------------------------------------------------
// adl32_pkg
// Shared types and constants for the eight-byte Adler-32 core.
// ----------------------------------------------------------------------------
package adl32_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_BYTES = 8;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned PROD_W    = BYTE_W + CNT_W;
  localparam int unsigned ADD1_W    = 11;   // 8 * 255
  localparam int unsigned ADD2_W    = 14;   // 36 * 255
  localparam int unsigned HACC_W    = 20;   // high + n*low + add2
  localparam int unsigned FOLD_W    = 17;

  localparam logic [SUM_W-1:0]  ADLER_MOD16 = 16'd65521;
  localparam logic [FOLD_W-1:0] ADLER_MOD17 = 17'd65521;
  localparam logic [FOLD_W-1:0] FOLD_MUL    = 17'd15;   // 2^16 mod 65521

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [ADD1_W-1:0] add1;
    logic [ADD2_W-1:0] add2;
    logic              start;
    logic              done;
  } sums_t;

  function automatic logic [SUM_W-1:0] mod_half(input logic [SUM_W-1:0] x);
    mod_half = (x >= ADLER_MOD16) ? (x - ADLER_MOD16) : x;
  endfunction

  function automatic logic [SUM_W-1:0] mod_fold(input logic [FOLD_W-1:0] x);
    logic [FOLD_W-1:0] d;
    d        = x - ADLER_MOD17;
    mod_fold = (x >= ADLER_MOD17) ? d[SUM_W-1:0] : x[SUM_W-1:0];
  endfunction

endpackage

// ----- hdl/adler32_checksum_8byte_core.sv -----
// ----------------------------------------------------------------------------
// adler32_checksum_8byte_core
// Adler-32 over a byte stream, up to eight bytes per transfer.
//
//   channel | dir | tdata                            | tuser | tlast
//   in_     | in  | [63:0] bytes, [67:64] byte count | start | end of stream
//   out_    | out | [31:0] checksum                  | -     | end of stream
//   cfg_    | in  | [31:0] seed (high:low)           | -     | -
//
// One transfer per cycle in while not stalled; one result per transfer out.
// The sum update (count times low sum, add, fold by 15) is combinational.
// Reset loads seed 1 and sums 1/0; no clearing pass.
// A stalled output freezes both stages; in_tready follows that stall.
// ----------------------------------------------------------------------------
module adler32_checksum_8byte_core #(
  parameter int unsigned LANES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,     // seed: [15:0] low sum, [31:16] high sum
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,      // [63:0] data_word, [67:64] byte_count
  input  logic        in_tuser,      // start_of_stream
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [31:0] checksum
  output logic        out_tlast
);

  localparam int unsigned NL = (LANES < adl32_pkg::MAX_BYTES) ? LANES : adl32_pkg::MAX_BYTES;

  logic                                 advance;
  logic [adl32_pkg::CNT_W-1:0]          cnt_in, n_sat;
  logic [NL-1:0][adl32_pkg::BYTE_W-1:0] lane_byte;
  logic [NL-1:0][adl32_pkg::PROD_W-1:0] lane_prod;
  adl32_pkg::sums_t                     s1;
  logic                                 s1_valid;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  assign cnt_in = in_tdata[67:64];
  assign n_sat  = (cnt_in > adl32_pkg::CNT_W'(NL)) ? adl32_pkg::CNT_W'(NL) : cnt_in;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    adl32_lane u_lane (
      .byte_i   (in_tdata[i*adl32_pkg::BYTE_W +: adl32_pkg::BYTE_W]),
      .lane_idx (adl32_pkg::CNT_W'(i)),
      .n_i      (n_sat),
      .byte_o   (lane_byte[i]),
      .wprod_o  (lane_prod[i])
    );
  end

  adl32_merge #(
    .NL (NL)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_take    (in_tvalid),
    .lane_byte  (lane_byte),
    .lane_prod  (lane_prod),
    .n_i        (n_sat),
    .start_i    (in_tuser),
    .done_i     (in_tlast),
    .s1_o       (s1),
    .s1_valid_o (s1_valid)
  );

  adl32_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .advance     (advance),
    .s1_i        (s1),
    .s1_valid_i  (s1_valid),
    .out_valid_o (out_tvalid),
    .checksum_o  (out_tdata),
    .done_o      (out_tlast)
  );

endmodule

// ----- hdl/adl32_lane.sv -----
// ----------------------------------------------------------------------------
// adl32_lane
// One byte lane: masks the byte by the count and forms its position weight.
// ----------------------------------------------------------------------------
module adl32_lane (
  input  logic [adl32_pkg::BYTE_W-1:0] byte_i,
  input  logic [adl32_pkg::CNT_W-1:0]  lane_idx,
  input  logic [adl32_pkg::CNT_W-1:0]  n_i,
  output logic [adl32_pkg::BYTE_W-1:0] byte_o,
  output logic [adl32_pkg::PROD_W-1:0] wprod_o
);

  logic                         live;
  logic [adl32_pkg::CNT_W-1:0]  weight;

  assign live    = lane_idx < n_i;
  assign weight  = live ? (n_i - lane_idx) : '0;
  assign byte_o  = live ? byte_i : '0;
  assign wprod_o = adl32_pkg::PROD_W'(weight) * adl32_pkg::PROD_W'(byte_i);

endmodule

// ----- hdl/adl32_merge.sv -----
// ----------------------------------------------------------------------------
// adl32_merge
// Adds up the lane results and registers them with the item controls.
// ----------------------------------------------------------------------------
module adl32_merge #(
  parameter int unsigned NL = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 advance,
  input  logic                                 in_take,
  input  logic [NL-1:0][adl32_pkg::BYTE_W-1:0] lane_byte,
  input  logic [NL-1:0][adl32_pkg::PROD_W-1:0] lane_prod,
  input  logic [adl32_pkg::CNT_W-1:0]          n_i,
  input  logic                                 start_i,
  input  logic                                 done_i,
  output adl32_pkg::sums_t                     s1_o,
  output logic                                 s1_valid_o
);

  logic [adl32_pkg::ADD1_W-1:0] add1;
  logic [adl32_pkg::ADD2_W-1:0] add2;
  adl32_pkg::sums_t             s1_r;
  logic                         s1_valid_r;

  always_comb begin
    add1 = '0;
    add2 = '0;
    for (int i = 0; i < NL; i++) begin
      add1 = add1 + adl32_pkg::ADD1_W'(lane_byte[i]);
      add2 = add2 + adl32_pkg::ADD2_W'(lane_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r.n     <= n_i;
      s1_r.add1  <= add1;
      s1_r.add2  <= add2;
      s1_r.start <= start_i;
      s1_r.done  <= done_i;
    end
  end

  assign s1_o       = s1_r;
  assign s1_valid_o = s1_valid_r;

endmodule

// ----- hdl/adl32_accum.sv -----
// ----------------------------------------------------------------------------
// adl32_accum
// Holds the seed and the two running sums; updates the sums once per transfer.
// ----------------------------------------------------------------------------
module adl32_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          advance,
  input  adl32_pkg::sums_t              s1_i,
  input  logic                          s1_valid_i,
  output logic                          out_valid_o,
  output logic [31:0]                   checksum_o,
  output logic                          done_o
);

  logic [adl32_pkg::SUM_W-1:0]  seed_lo_r, seed_hi_r;
  logic [adl32_pkg::SUM_W-1:0]  low_r, high_r, low_nxt, high_nxt;
  logic [adl32_pkg::SUM_W-1:0]  low_base, high_base;
  logic [adl32_pkg::HACC_W-1:0] prod, hacc;
  logic [adl32_pkg::FOLD_W-1:0] hfold, lacc;
  logic                         out_valid_r, done_r;
  logic                         take;

  assign take      = advance && s1_valid_i;
  assign low_base  = s1_i.start ? seed_lo_r : low_r;
  assign high_base = s1_i.start ? seed_hi_r : high_r;

  always_comb begin
    prod  = adl32_pkg::HACC_W'(s1_i.n) * adl32_pkg::HACC_W'(low_base);
    hacc  = adl32_pkg::HACC_W'(high_base) + prod + adl32_pkg::HACC_W'(s1_i.add2);
    hfold = adl32_pkg::FOLD_W'(hacc[adl32_pkg::HACC_W-1:adl32_pkg::SUM_W])
            * adl32_pkg::FOLD_MUL
            + adl32_pkg::FOLD_W'(hacc[adl32_pkg::SUM_W-1:0]);
    lacc  = adl32_pkg::FOLD_W'(low_base) + adl32_pkg::FOLD_W'(s1_i.add1);
    high_nxt = adl32_pkg::mod_fold(hfold);
    low_nxt  = adl32_pkg::mod_fold(lacc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_lo_r   <= 16'd1;
      seed_hi_r   <= 16'd0;
      low_r       <= 16'd1;
      high_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_lo_r <= adl32_pkg::mod_half(cfg_wdata[15:0]);
        seed_hi_r <= adl32_pkg::mod_half(cfg_wdata[31:16]);
      end
      if (advance) begin
        out_valid_r <= s1_valid_i;
      end
      if (take) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      done_r <= s1_i.done;
    end
  end

  assign out_valid_o = out_valid_r;
  assign checksum_o  = {high_r, low_r};
  assign done_o      = done_r;

endmodule
